/* src/ffra_pkg.sv */
package ffra_pkg;

  localparam int MaxEntries = 16;
  localparam int MaxUnits   = 4096;
  localparam int IdxW       = $clog2(MaxEntries);
  localparam int CntW       = $clog2(MaxEntries + 1);
  localparam int StartW     = 12;
  localparam int SizeW      = 13;
  localparam int CandW      = 13;
  localparam int SpanW      = 14;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_BAD_FREE = 2'd3;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Search token that walks the row of cells.
  typedef struct packed {
    logic              kind;
    logic [CandW-1:0]  cand;
    logic [SizeW-1:0]  units;
    logic              changed;
    logic [StartW-1:0] foff_units;
    logic              foff_aligned;
    logic              found;
    logic [IdxW-1:0]   idx;
    logic [SizeW-1:0]  fsize;
  } tok_t;

  // Entry write broadcast to all cells.
  typedef struct packed {
    logic              en;
    logic [IdxW-1:0]   idx;
    logic [StartW-1:0] start;
    logic [SizeW-1:0]  size;
  } wr_t;

endpackage

/* src/first_fit_region_allocator.sv */
// A rejected request goes straight to the pending state; a searched one sends a token
// through the 16-cell row, which is reinjected after every allocation pass that moved
// its candidate and makes at most 17 passes. One transaction at a time: a new request
// is taken only in the idle state, once the previous result is in the output register.
// Reset (rst, synchronous) empties the table, clears the used byte total and sets
// the capacity to 4096 units; entry contents stay undefined until written.
module first_fit_region_allocator import ffra_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [12:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [16:0] amount,
  input  logic [15:0] free_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] alloc_offset,
  output logic [16:0] used_bytes,
  output logic [4:0]  live_entries
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_PEND = 2'd2;

  logic [1:0]       state;
  logic [12:0]      capacity;
  logic [CntW-1:0]  live_count;
  logic [16:0]      used_total;

  // Pending result, held until the output register is free.
  logic [1:0]       pend_status;
  logic [15:0]      pend_offset;

  logic             inj_valid;
  logic             inj_valid_next;
  tok_t             inj_tok;
  tok_t             first_tok;
  tok_t             retry_tok;
  wr_t              wr;

  logic             chain_valid [MaxEntries+1];
  tok_t             chain_tok   [MaxEntries+1];
  logic [StartW-1:0] cell_start [MaxEntries];
  logic [SizeW-1:0]  cell_size  [MaxEntries];

  logic [SizeW-1:0] cap_eff;
  logic [13:0]      req_units;
  logic             ret_valid;
  tok_t             ret_tok;
  logic [SpanW-1:0] ret_end;
  logic [IdxW-1:0]  last_idx;
  logic             no_space;
  logic             tbl_full;
  logic             retry;

  assign cap_eff   = (capacity > 13'(MaxUnits)) ? 13'(MaxUnits) : capacity;
  assign req_units = 14'(({1'b0, amount} + 18'd15) >> 4);
  assign ret_valid = chain_valid[MaxEntries];
  assign ret_tok   = chain_tok[MaxEntries];
  assign ret_end   = {1'b0, ret_tok.cand} + {1'b0, ret_tok.units};
  assign last_idx  = IdxW'(live_count - CntW'(1));

  // Early rejections: zero or oversized requests first, then a full table.
  assign no_space = (req_type == REQ_ALLOC) &&
                    (amount == 17'd0 || req_units > {1'b0, cap_eff});
  assign tbl_full = (req_type == REQ_ALLOC) && (live_count == CntW'(MaxEntries));

  // A token that moved its candidate and still fits goes round again.
  assign retry = (state == S_SCAN) && ret_valid && (ret_tok.kind == REQ_ALLOC) &&
                 (ret_end <= {1'b0, cap_eff}) && ret_tok.changed;

  assign inj_valid_next = ((state == S_IDLE) && in_valid && !no_space && !tbl_full) ||
                          retry;

  assign in_ready  = (state == S_IDLE);

  assign chain_valid[0] = inj_valid;
  assign chain_tok[0]   = inj_tok;

  always_comb begin
    first_tok              = '0;
    first_tok.kind         = req_type;
    first_tok.units        = SizeW'(req_units);
    first_tok.foff_units   = free_offset[15:4];
    first_tok.foff_aligned = (free_offset[3:0] == 4'd0);
  end

  always_comb begin
    retry_tok         = ret_tok;
    retry_tok.changed = 1'b0;
  end

  // The row of cells; each holds one table slot and a token stage.
  for (genvar k = 0; k < MaxEntries; k++) begin : g_cell
    ffra_cell u_cell (
      .clk           (clk),
      .rst           (rst),
      .cell_idx      (IdxW'(k)),
      .live_count    (live_count),
      .wr            (wr),
      .tok_in_valid  (chain_valid[k]),
      .tok_in        (chain_tok[k]),
      .tok_out_valid (chain_valid[k+1]),
      .tok_out       (chain_tok[k+1]),
      .start         (cell_start[k]),
      .size          (cell_size[k])
    );
  end

  always_comb begin
    wr = '0;
    if (state == S_SCAN && ret_valid) begin
      if (ret_tok.kind == REQ_ALLOC) begin
        wr.en    = (ret_end <= {1'b0, cap_eff}) && !ret_tok.changed;
        wr.idx   = IdxW'(live_count);
        wr.start = StartW'(ret_tok.cand);
        wr.size  = ret_tok.units;
      end else begin
        // Removal moves the last live entry into the freed slot.
        wr.en    = ret_tok.found;
        wr.idx   = ret_tok.idx;
        wr.start = cell_start[last_idx];
        wr.size  = cell_size[last_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      capacity   <= 13'd4096;
      live_count <= '0;
      used_total <= '0;
      inj_valid  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      inj_valid <= inj_valid_next;
      if (cfg_wen) begin
        capacity <= cfg_wdata;
      end
      // The output register is loaded in S_PEND and emptied by the receiver.
      if (state == S_PEND) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            pend_offset <= '0;
            inj_tok     <= first_tok;
            if (no_space) begin
              pend_status <= ST_NO_SPACE;
              state       <= S_PEND;
            end else if (tbl_full) begin
              pend_status <= ST_FULL;
              state       <= S_PEND;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (ret_valid) begin
            if (ret_tok.kind == REQ_ALLOC) begin
              if (ret_end > {1'b0, cap_eff}) begin
                pend_status <= ST_NO_SPACE;
                state       <= S_PEND;
              end else if (ret_tok.changed) begin
                // Another pass: the candidate moved, so earlier cells need rechecking.
                inj_tok <= retry_tok;
              end else begin
                pend_status <= ST_OK;
                pend_offset <= {ret_tok.cand[11:0], 4'd0};
                live_count  <= live_count + CntW'(1);
                used_total  <= used_total + {ret_tok.units, 4'd0};
                state       <= S_PEND;
              end
            end else begin
              if (ret_tok.found) begin
                pend_status <= ST_OK;
                live_count  <= live_count - CntW'(1);
                used_total  <= used_total - {ret_tok.fsize, 4'd0};
              end else begin
                pend_status <= ST_BAD_FREE;
              end
              state <= S_PEND;
            end
          end
        end
        S_PEND: begin
          if (!out_valid || out_ready) begin
            status       <= pend_status;
            alloc_offset <= pend_offset;
            used_bytes   <= used_total;
            live_entries <= 5'(live_count);
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live_count <= CntW'(MaxEntries))
    else $error("live count exceeds table depth");

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    inj_valid |-> (state == S_SCAN) && !ret_valid)
    else $error("second search token injected");

  a_alloc_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && ret_valid && ret_tok.kind == REQ_ALLOC && wr.en)
      |=> live_count == $past(live_count) + CntW'(1))
    else $error("granted allocation did not add an entry");

endmodule

/* src/ffra_cell.sv */
module ffra_cell import ffra_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [IdxW-1:0]   cell_idx,
  input  logic [CntW-1:0]   live_count,
  input  wr_t               wr,
  input  logic              tok_in_valid,
  input  tok_t              tok_in,
  output logic              tok_out_valid,
  output tok_t              tok_out,
  output logic [StartW-1:0] start,
  output logic [SizeW-1:0]  size
);

  logic             live;
  logic [CandW-1:0] entry_end;
  logic [SpanW-1:0] cand_end;
  logic             hit;
  tok_t             tok_next;

  assign live      = {1'b0, cell_idx} < live_count;
  assign entry_end = {1'b0, start} + size;
  assign cand_end  = {1'b0, tok_in.cand} + {1'b0, tok_in.units};

  always_comb begin
    tok_next = tok_in;
    hit = 1'b0;
    if (tok_in.kind == REQ_ALLOC) begin
      // An overlapping entry pushes the candidate to its end.
      hit = live && (tok_in.cand < entry_end) && ({2'b00, start} < cand_end);
      if (hit) begin
        tok_next.cand    = entry_end;
        tok_next.changed = 1'b1;
      end
    end else begin
      hit = live && !tok_in.found && tok_in.foff_aligned && (start == tok_in.foff_units);
      if (hit) begin
        tok_next.found = 1'b1;
        tok_next.idx   = cell_idx;
        tok_next.fsize = size;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out_valid <= 1'b0;
    end else begin
      tok_out_valid <= tok_in_valid;
    end
    tok_out <= tok_next;
    if (wr.en && wr.idx == cell_idx) begin
      start <= wr.start;
      size  <= wr.size;
    end
  end

endmodule
